>>> design/zsd_pkg.sv
`timescale 1ns / 1ps

package zsd_pkg;

	// signed width for span arithmetic: an 8-bit column plus insets, minus insets
	localparam int SPW = 10;

	localparam int EDGE_INSET  = 3;
	localparam int MIN_SPAN    = 10;
	localparam int BLACK_SHIFT = 3;
	localparam int MARGIN_GAP  = 2;
	localparam int WIDTH_DIV   = 5;

	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	localparam logic [7:0] RST_MARGIN_LOW  = 8'd1;
	localparam logic [7:0] RST_MARGIN_HIGH = 8'd158;
	localparam logic [7:0] RST_WIN_TOP     = 8'd40;
	localparam logic [7:0] RST_WIN_BOTTOM  = 8'd96;
	localparam logic [7:0] RST_MIN_CHANGES = 8'd4;
	localparam logic [7:0] RST_MIN_ROWS    = 8'd3;

	typedef logic signed [SPW-1:0] span_t;

	typedef enum logic [2:0] {
		REG_MARGIN_LOW  = 3'd0,
		REG_MARGIN_HIGH = 3'd1,
		REG_WIN_TOP     = 3'd2,
		REG_WIN_BOTTOM  = 3'd3,
		REG_MIN_CHANGES = 3'd4,
		REG_MIN_ROWS    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic       pixel_black;
		logic [7:0] pixel_col;
		logic [6:0] pixel_row;
		logic [7:0] left_edge;
		logic [7:0] right_edge;
		logic       last_in_row;
		logic       last_in_frame;
	} pix_t;

	typedef struct packed {
		logic        zebra_found;
		logic [15:0] change_total;
		logic [6:0]  striped_rows;
		logic [6:0]  black_rows;
		logic [6:0]  used_rows;
	} res_t;

	function automatic span_t to_span(input logic [7:0] v);
		return span_t'({{(SPW-8){1'b0}}, v});
	endfunction

	function automatic span_t clamp_span(input span_t v, input span_t lo, input span_t hi);
		span_t r;
		r = v;
		if (r < lo) begin
			r = lo;
		end
		if (r > hi) begin
			r = hi;
		end
		return r;
	endfunction

	function automatic logic [6:0] sat_inc7(input logic [6:0] v);
		return (v != 7'h7F) ? v + 7'd1 : v;
	endfunction

endpackage

>>> design/zsd_pix_if.sv
`timescale 1ns / 1ps

interface zsd_pix_if;
	logic          valid;
	logic          ready;
	zsd_pkg::pix_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> design/zsd_res_if.sv
`timescale 1ns / 1ps

interface zsd_res_if;
	logic          valid;
	logic          ready;
	zsd_pkg::res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> design/zebra_stripe_detector.sv
`timescale 1ns / 1ps
// a pixel taken into the input register stage is evaluated there; a frame verdict
// is registered in the result register as its last pixel leaves that stage, and held on res
// throughput: one pixel per clock, set by the single input register stage feeding the
// tally update; it stalls only when a verdict waits and the result register is full
// reset (arst_n low, asynchronous): config returns to defaults, all tallies and valids clear

module zebra_stripe_detector #(
	parameter int IMG_WIDTH  = 160,
	parameter int IMG_HEIGHT = 120
) (
	input  logic                               clk,
	input  logic                               arst_n,
	zsd_pix_if.sink                            pix,
	zsd_res_if.source                          res,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [zsd_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [zsd_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [zsd_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                               pready
);

	// span limits and track width window, fixed at elaboration
	localparam zsd_pkg::span_t SL_MAX    = zsd_pkg::span_t'(IMG_WIDTH - 2);
	localparam zsd_pkg::span_t SR_MAX    = zsd_pkg::span_t'(IMG_WIDTH - 1);
	localparam zsd_pkg::span_t WIDTH_MIN = zsd_pkg::span_t'(IMG_WIDTH / zsd_pkg::WIDTH_DIV);
	localparam zsd_pkg::span_t WIDTH_MAX = zsd_pkg::span_t'(IMG_WIDTH - 5);
	localparam logic [7:0]     ROW_LIMIT = 8'(IMG_HEIGHT);

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [7:0] margin_low_q;
	logic [7:0] margin_high_q;
	logic [7:0] win_top_q;
	logic [7:0] win_bottom_q;
	logic [7:0] min_changes_q;
	logic [7:0] min_rows_q;

	zsd_pkg::cfg_reg_t cfg_idx;
	logic              cfg_wr;

	assign cfg_idx = zsd_pkg::cfg_reg_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_low_q  <= zsd_pkg::RST_MARGIN_LOW;
			margin_high_q <= zsd_pkg::RST_MARGIN_HIGH;
			win_top_q     <= zsd_pkg::RST_WIN_TOP;
			win_bottom_q  <= zsd_pkg::RST_WIN_BOTTOM;
			min_changes_q <= zsd_pkg::RST_MIN_CHANGES;
			min_rows_q    <= zsd_pkg::RST_MIN_ROWS;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				zsd_pkg::REG_MARGIN_LOW:  margin_low_q  <= pwdata[7:0];
				zsd_pkg::REG_MARGIN_HIGH: margin_high_q <= pwdata[7:0];
				zsd_pkg::REG_WIN_TOP:     win_top_q     <= pwdata[7:0];
				zsd_pkg::REG_WIN_BOTTOM:  win_bottom_q  <= pwdata[7:0];
				zsd_pkg::REG_MIN_CHANGES: min_changes_q <= pwdata[7:0];
				zsd_pkg::REG_MIN_ROWS:    min_rows_q    <= pwdata[7:0];
				default: ;  // addresses past the register list are ignored
			endcase
		end
	end

	// read back, zero-extended
	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			zsd_pkg::REG_MARGIN_LOW:  prdata[7:0] = margin_low_q;
			zsd_pkg::REG_MARGIN_HIGH: prdata[7:0] = margin_high_q;
			zsd_pkg::REG_WIN_TOP:     prdata[7:0] = win_top_q;
			zsd_pkg::REG_WIN_BOTTOM:  prdata[7:0] = win_bottom_q;
			zsd_pkg::REG_MIN_CHANGES: prdata[7:0] = min_changes_q;
			zsd_pkg::REG_MIN_ROWS:    prdata[7:0] = min_rows_q;
			default:                  prdata      = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// input register stage
	// ---------------------------------------------------------------
	zsd_pkg::pix_t pix_s1;
	logic          pix_valid_s1;
	logic          res_valid_q;
	zsd_pkg::res_t res_data_q;
	logic          out_free;
	logic          s1_go;      // stage 1 item is consumed this cycle
	logic          s1_fire;

	// the result slot frees up when empty or when its transaction completes
	assign out_free = !res_valid_q || res.ready;
	// only a frame-closing pixel needs the result slot
	assign s1_go    = !pix_s1.last_in_frame || out_free;
	assign s1_fire  = pix_valid_s1 && s1_go;
	assign pix.ready = !pix_valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			pix_valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.ready && pix.valid) begin
			pix_s1 <= pix.data;
		end
	end

	// ---------------------------------------------------------------
	// per-pixel span tests and row/frame tallies
	// ---------------------------------------------------------------
	logic        prev_pixel_q;
	logic [7:0]  row_chg_q;
	logic [7:0]  row_blk_q;
	logic [15:0] frame_sum_q;
	logic [6:0]  striped_q;
	logic [6:0]  black_q;
	logic [6:0]  used_q;

	zsd_pkg::span_t left_s;
	zsd_pkg::span_t right_s;
	zsd_pkg::span_t col_s;
	zsd_pkg::span_t sl;
	zsd_pkg::span_t sr;
	zsd_pkg::span_t track_w;
	logic           black_hit;
	logic           chg_hit;
	logic [7:0]     row_chg_nx;
	logic [7:0]     row_blk_nx;
	logic           row_in_win;
	logic           row_used;
	logic [16:0]    sum_wide;
	logic [15:0]    frame_sum_nx;
	logic [6:0]     striped_nx;
	logic [6:0]     black_nx;
	logic [6:0]     used_nx;

	always_comb begin
		left_s  = zsd_pkg::to_span(pix_s1.left_edge);
		right_s = zsd_pkg::to_span(pix_s1.right_edge);
		col_s   = zsd_pkg::to_span(pix_s1.pixel_col);

		// scanned span, inset from the borders and kept inside the image
		sl = zsd_pkg::clamp_span(left_s + zsd_pkg::span_t'(zsd_pkg::EDGE_INSET),
			zsd_pkg::span_t'(0), SL_MAX);
		sr = zsd_pkg::clamp_span(right_s - zsd_pkg::span_t'(zsd_pkg::EDGE_INSET),
			zsd_pkg::span_t'(1), SR_MAX);

		// black pixels count over [sl, sr-2], changes over [sl+1, sr-1]
		black_hit = pix_s1.pixel_black && (col_s >= sl)
			&& (col_s <= sr - zsd_pkg::span_t'(2));
		chg_hit   = (col_s >= sl + zsd_pkg::span_t'(1))
			&& (col_s <= sr - zsd_pkg::span_t'(1))
			&& (pix_s1.pixel_black != prev_pixel_q);

		// row tallies saturate at all ones
		row_chg_nx = (chg_hit && row_chg_q != 8'hFF) ? row_chg_q + 8'd1 : row_chg_q;
		row_blk_nx = (black_hit && row_blk_q != 8'hFF) ? row_blk_q + 8'd1 : row_blk_q;

		// row qualification uses the closing pixel's row and borders
		track_w    = right_s - left_s;
		row_in_win = ({1'b0, pix_s1.pixel_row} < ROW_LIMIT)
			&& ({1'b0, pix_s1.pixel_row} >= win_top_q)
			&& ({1'b0, pix_s1.pixel_row} <= win_bottom_q);
		row_used   = pix_s1.last_in_row && row_in_win
			&& (left_s > zsd_pkg::to_span(margin_low_q) + zsd_pkg::span_t'(zsd_pkg::MARGIN_GAP))
			&& (right_s < zsd_pkg::to_span(margin_high_q) - zsd_pkg::span_t'(zsd_pkg::MARGIN_GAP))
			&& (track_w >= WIDTH_MIN) && (track_w <= WIDTH_MAX)
			&& (sr > sl + zsd_pkg::span_t'(zsd_pkg::MIN_SPAN));

		// frame tallies after closing this row
		sum_wide     = {1'b0, frame_sum_q} + {9'd0, row_chg_nx};
		frame_sum_nx = frame_sum_q;
		striped_nx   = striped_q;
		black_nx     = black_q;
		used_nx      = used_q;
		if (row_used) begin
			frame_sum_nx = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];
			used_nx      = zsd_pkg::sat_inc7(used_q);
			if (row_chg_nx >= min_changes_q) begin
				striped_nx = zsd_pkg::sat_inc7(striped_q);
			end
			// one eighth of the span; span is positive whenever the row is used
			if (zsd_pkg::to_span(row_blk_nx) >= ((sr - sl) >>> zsd_pkg::BLACK_SHIFT)) begin
				black_nx = zsd_pkg::sat_inc7(black_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pixel_q <= 1'b0;
			row_chg_q    <= '0;
			row_blk_q    <= '0;
			frame_sum_q  <= '0;
			striped_q    <= '0;
			black_q      <= '0;
			used_q       <= '0;
		end else if (s1_fire) begin
			prev_pixel_q <= pix_s1.pixel_black;
			if (pix_s1.last_in_row || pix_s1.last_in_frame) begin
				// row closes, or an open row is dropped at frame end
				row_chg_q <= '0;
				row_blk_q <= '0;
			end else begin
				row_chg_q <= row_chg_nx;
				row_blk_q <= row_blk_nx;
			end
			if (pix_s1.last_in_frame) begin
				frame_sum_q <= '0;
				striped_q   <= '0;
				black_q     <= '0;
				used_q      <= '0;
			end else begin
				frame_sum_q <= frame_sum_nx;
				striped_q   <= striped_nx;
				black_q     <= black_nx;
				used_q      <= used_nx;
			end
		end
	end

	// ---------------------------------------------------------------
	// result register: holds one frame verdict until its transaction
	// ---------------------------------------------------------------
	logic res_load;

	assign res_load = s1_fire && pix_s1.last_in_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_data_q.zebra_found  <= ({1'b0, striped_nx} >= min_rows_q)
				&& ({1'b0, black_nx} >= min_rows_q);
			res_data_q.change_total <= frame_sum_nx;
			res_data_q.striped_rows <= striped_nx;
			res_data_q.black_rows   <= black_nx;
			res_data_q.used_rows    <= used_nx;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	a_row_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(striped_q <= used_q) && (black_q <= used_q))
		else $error("striped or black row count exceeds used row count");

	a_result_from_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(pix_valid_s1 && pix_s1.last_in_frame))
		else $error("result appeared without a frame-closing pixel");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (used_q == 7'd0) && (frame_sum_q == 16'd0) && (row_chg_q == 8'd0))
		else $error("frame tallies not cleared after verdict");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid_s1 && !s1_go) |=> (pix_valid_s1 && $stable(pix_s1)))
		else $error("stalled stage 1 item changed");

endmodule

>>> sim/zebra_stripe_detector_tb.sv
`timescale 1ns / 1ps

module zebra_stripe_detector_tb;

	localparam int IMG_WIDTH     = 160;
	localparam int IMG_HEIGHT    = 120;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 400;
	localparam int N_PHASES      = 8;
	localparam longint CYCLE_LIMIT = 1000000;

	// one full register set, in register index order
	typedef struct packed {
		logic [7:0] margin_low, margin_high, win_top, win_bottom, min_changes, min_rows;
	} cfg_set_t;

	// directed stimulus row: pixel, and a verdict typed in where it is obvious
	typedef struct {
		zsd_pkg::pix_t px;
		bit            typed;
		zsd_pkg::res_t want;
	} dir_row_t;

	localparam int DIR_N = 21;

	// fields: black, col, row, left, right, last_in_row, last_in_frame
	dir_row_t dir_tab [DIR_N] = '{
		// frame end right after reset, nothing counted
		'{'{1'b0, 8'd0, 7'd0, 8'd0, 8'd0, 1'b0, 1'b1}, 1'b1, '{1'b0, 16'd0, 7'd0, 7'd0, 7'd0}},
		// one used row with a single black pixel, one change
		'{'{1'b1, 8'd30, 7'd50, 8'd20, 8'd100, 1'b1, 1'b0}, 1'b0, '0},
		// row outside the window closes the frame
		'{'{1'b0, 8'd0, 7'd0, 8'd20, 8'd100, 1'b1, 1'b1}, 1'b1, '{1'b0, 16'd1, 7'd0, 7'd0, 7'd1}},
		// all fields but last_in_frame at their top values, column off the image
		'{'{1'b1, 8'd255, 7'd127, 8'd255, 8'd255, 1'b1, 1'b0}, 1'b0, '0},
		// span limits on a wide row
		'{'{1'b1, 8'd159, 7'd96, 8'd0, 8'd159, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b0, 8'd3, 7'd96, 8'd0, 8'd159, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b0, 8'd4, 7'd96, 8'd0, 8'd159, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b1, 8'd4, 7'd96, 8'd0, 8'd159, 1'b0, 1'b0}, 1'b0, '0},
		// closing pixel carries other edges, narrowest legal width
		'{'{1'b1, 8'd154, 7'd96, 8'd4, 8'd36, 1'b1, 1'b0}, 1'b0, '0},
		// left border on the margin
		'{'{1'b0, 8'd50, 7'd40, 8'd3, 8'd100, 1'b1, 1'b0}, 1'b0, '0},
		// just above the window
		'{'{1'b1, 8'd50, 7'd39, 8'd20, 8'd155, 1'b1, 1'b0}, 1'b0, '0},
		// just below the window
		'{'{1'b0, 8'd50, 7'd97, 8'd20, 8'd100, 1'b1, 1'b0}, 1'b0, '0},
		// right border on the margin
		'{'{1'b1, 8'd50, 7'd40, 8'd20, 8'd156, 1'b1, 1'b0}, 1'b0, '0},
		// width one short, then exactly the minimum
		'{'{1'b0, 8'd30, 7'd40, 8'd20, 8'd51, 1'b1, 1'b0}, 1'b0, '0},
		'{'{1'b1, 8'd30, 7'd40, 8'd20, 8'd52, 1'b1, 1'b0}, 1'b0, '0},
		// row index past the image height
		'{'{1'b0, 8'd255, 7'd120, 8'd20, 8'd100, 1'b1, 1'b0}, 1'b0, '0},
		// frame end on an open row
		'{'{1'b1, 8'd30, 7'd60, 8'd20, 8'd100, 1'b0, 1'b1}, 1'b0, '0},
		// edges and row index drift inside a row, frame closes with the row
		'{'{1'b0, 8'd24, 7'd60, 8'd20, 8'd100, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b1, 8'd25, 7'd60, 8'd20, 8'd100, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b0, 8'd26, 7'd60, 8'd30, 8'd110, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b1, 8'd27, 7'd61, 8'd40, 8'd80, 1'b1, 1'b1}, 1'b0, '0}
	};

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [zsd_pkg::CFG_ADDR_W-1:0] paddr;
	logic [zsd_pkg::CFG_DATA_W-1:0] pwdata;
	logic [zsd_pkg::CFG_DATA_W-1:0] prdata;
	logic                           pready;

	zsd_pix_if pix_if ();
	zsd_res_if res_if ();

	zebra_stripe_detector #(
		.IMG_WIDTH (IMG_WIDTH),
		.IMG_HEIGHT(IMG_HEIGHT)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_if),
		.res    (res_if),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// predictor copy of the registers and tallies
	cfg_set_t   cfg;
	logic       prev_black;
	logic [7:0] row_changes;
	logic [7:0] row_blacks;
	int         change_sum;
	logic [6:0] striped_cnt;
	logic [6:0] black_cnt;
	logic [6:0] used_cnt;

	// verdicts still owed by the block, oldest first
	zsd_pkg::res_t verdict_q [$];
	bit            failed = 1'b0;
	longint        cycles = 0;
	int            pixels_sent = 0;
	bit            burst = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("zebra_stripe_detector: mismatch");
			$finish;
		end
	end

	// per-pixel update of the tallies; returns 1 when the pixel closes a frame
	function automatic bit predict_pixel(input zsd_pkg::pix_t p, output zsd_pkg::res_t v);
		int col, row, lft, rgt, sl, sr, mlo, mhi, top, bot;
		bit used;
		col = int'(p.pixel_col);
		row = int'(p.pixel_row);
		lft = int'(p.left_edge);
		rgt = int'(p.right_edge);
		mlo = int'(cfg.margin_low);
		mhi = int'(cfg.margin_high);
		top = int'(cfg.win_top);
		bot = int'(cfg.win_bottom);
		v = '0;

		// scan span, clamped into the image
		sl = lft + zsd_pkg::EDGE_INSET;
		if (sl > IMG_WIDTH - 2) sl = IMG_WIDTH - 2;
		sr = rgt - zsd_pkg::EDGE_INSET;
		if (sr < 1) sr = 1;
		if (sr > IMG_WIDTH - 1) sr = IMG_WIDTH - 1;

		if (col >= sl && col <= sr - 2 && p.pixel_black && row_blacks != 8'hFF)
			row_blacks++;
		if (col >= sl + 1 && col <= sr - 1 && p.pixel_black != prev_black
				&& row_changes != 8'hFF)
			row_changes++;
		prev_black = p.pixel_black;

		if (p.last_in_row) begin
			// the closing pixel's row and edges decide whether the row counts
			used = row < IMG_HEIGHT && row >= top && row <= bot
				&& lft > mlo + zsd_pkg::MARGIN_GAP && rgt < mhi - zsd_pkg::MARGIN_GAP
				&& rgt - lft >= IMG_WIDTH / zsd_pkg::WIDTH_DIV && rgt - lft <= IMG_WIDTH - 5
				&& sr > sl + zsd_pkg::MIN_SPAN;
			if (used) begin
				if (used_cnt != 7'h7F) used_cnt++;
				change_sum = change_sum + int'(row_changes);
				if (change_sum > 65535) change_sum = 65535;
				if (row_changes >= cfg.min_changes && striped_cnt != 7'h7F)
					striped_cnt++;
				if (int'(row_blacks) >= ((sr - sl) >>> zsd_pkg::BLACK_SHIFT)
						&& black_cnt != 7'h7F)
					black_cnt++;
			end
			row_changes = '0;
			row_blacks  = '0;
		end

		if (p.last_in_frame) begin
			v.zebra_found  = striped_cnt >= cfg.min_rows && black_cnt >= cfg.min_rows;
			v.change_total = change_sum[15:0];
			v.striped_rows = striped_cnt;
			v.black_rows   = black_cnt;
			v.used_rows    = used_cnt;
			// open row tallies are dropped along with the frame
			row_changes = '0;
			row_blacks  = '0;
			change_sum  = 0;
			striped_cnt = '0;
			black_cnt   = '0;
			used_cnt    = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// one pixel transaction; the verdict is queued once the pixel is taken
	task automatic send_pixel(input zsd_pkg::pix_t p, input bit typed = 1'b0,
			input zsd_pkg::res_t want = '0);
		int gap;
		zsd_pkg::res_t v;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.data  <= p;
		do @(posedge clk); while (pix_if.ready !== 1'b1);
		if (predict_pixel(p, v))
			verdict_q.push_back(typed ? want : v);
		pixels_sent++;
	endtask

	// stop the stream and let every owed verdict and the pipeline drain
	task automatic drain();
		@(negedge clk);
		pix_if.valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup phase, then access phase; the write lands at the access edge
	task automatic write_reg(input zsd_pkg::cfg_reg_t idx, input logic [7:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= zsd_pkg::CFG_DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_cfg(input cfg_set_t s);
		write_reg(zsd_pkg::REG_MARGIN_LOW, s.margin_low);
		write_reg(zsd_pkg::REG_MARGIN_HIGH, s.margin_high);
		write_reg(zsd_pkg::REG_WIN_TOP, s.win_top);
		write_reg(zsd_pkg::REG_WIN_BOTTOM, s.win_bottom);
		write_reg(zsd_pkg::REG_MIN_CHANGES, s.min_changes);
		write_reg(zsd_pkg::REG_MIN_ROWS, s.min_rows);
		cfg = s;
	endtask

	// a frame of a few rows, mostly well formed with random stripe content
	task automatic gen_frame();
		int nrows, npix, row, lft, rgt, col, step, style, period;
		bit open_end;
		zsd_pkg::pix_t p;
		burst = ($urandom_range(0, 3) == 0);
		nrows = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
		open_end = ($urandom_range(0, 9) == 0);
		for (int r = 0; r < nrows; r++) begin
			row = ($urandom_range(0, 9) < 7) ? $urandom_range(30, 100) : $urandom_range(0, 127);
			if ($urandom_range(0, 3) != 0) begin
				lft = $urandom_range(0, 70);
				rgt = lft + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 159)
					: $urandom_range(30, 70));
				if (rgt > 255) rgt = 255;
			end else begin
				lft = $urandom_range(0, 255);
				rgt = $urandom_range(0, 255);
			end
			// now and then a row long enough to saturate the row tallies
			case ($urandom_range(0, 49))
				0: begin
					npix = $urandom_range(256, 300);
				end
				1, 2, 3, 4: begin
					npix = $urandom_range(17, 60);
				end
				default: begin
					npix = $urandom_range(1, 16);
				end
			endcase
			style  = $urandom_range(0, 3);
			period = $urandom_range(1, 3);
			col    = lft + $urandom_range(0, 6);
			step   = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
			for (int i = 0; i < npix; i++) begin
				case (style)
					0: begin
						p.pixel_black = 1'((i / period) % 2);
					end
					1: begin
						p.pixel_black = 1'($urandom_range(0, 1));
					end
					2: begin
						p.pixel_black = 1'b1;
					end
					default: begin
						p.pixel_black = (i % 4 != 0);
					end
				endcase
				p.pixel_col = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'(col);
				p.pixel_row = ($urandom_range(0, 49) == 0) ? 7'($urandom) : 7'(row);
				if ($urandom_range(0, 29) == 0) begin
					p.left_edge  = 8'($urandom);
					p.right_edge = 8'($urandom);
				end else begin
					p.left_edge  = 8'(lft);
					p.right_edge = 8'(rgt);
				end
				// an open frame ends on a pixel that does not close its row
				p.last_in_row   = (i == npix - 1) && !(open_end && r == nrows - 1);
				p.last_in_frame = (i == npix - 1) && (r == nrows - 1);
				send_pixel(p);
				col = col + step;
				if (col > 255) col = lft;
			end
		end
	endtask

	// verdict receiver with random stalls
	initial begin
		int hold;
		int pick;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				res_if.ready <= 1'b1;
				hold = $urandom_range(1, 20);
			end else if (pick < 85) begin
				res_if.ready <= 1'b0;
				hold = $urandom_range(1, 3);
			end else begin
				res_if.ready <= 1'b0;
				hold = $urandom_range(5, 40);
			end
			repeat (hold - 1) @(negedge clk);
		end
	end

	// compare each verdict transaction with the oldest owed verdict
	always @(posedge clk) begin : check_verdict
		zsd_pkg::res_t want;
		if (arst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (verdict_q.size() == 0) begin
				$error("verdict transaction with none owed");
				failed = 1'b1;
			end else begin
				want = verdict_q.pop_front();
				if (res_if.data.zebra_found !== want.zebra_found) begin
					$error("zebra_found: expected %0d, got %0d",
						want.zebra_found, res_if.data.zebra_found);
					failed = 1'b1;
				end
				if (res_if.data.change_total !== want.change_total) begin
					$error("change_total: expected %0d, got %0d",
						want.change_total, res_if.data.change_total);
					failed = 1'b1;
				end
				if (res_if.data.striped_rows !== want.striped_rows) begin
					$error("striped_rows: expected %0d, got %0d",
						want.striped_rows, res_if.data.striped_rows);
					failed = 1'b1;
				end
				if (res_if.data.black_rows !== want.black_rows) begin
					$error("black_rows: expected %0d, got %0d",
						want.black_rows, res_if.data.black_rows);
					failed = 1'b1;
				end
				if (res_if.data.used_rows !== want.used_rows) begin
					$error("used_rows: expected %0d, got %0d",
						want.used_rows, res_if.data.used_rows);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		cfg_set_t      phase_cfg [N_PHASES];
		cfg_set_t      open_cfg;
		logic [63:0]   raw;
		zsd_pkg::pix_t p;
		int            goal;

		// everything driven known from time zero
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		pix_if.valid = 1'b0;
		pix_if.data  = '0;

		// predictor starts from the reset values
		cfg = '{zsd_pkg::RST_MARGIN_LOW, zsd_pkg::RST_MARGIN_HIGH, zsd_pkg::RST_WIN_TOP,
			zsd_pkg::RST_WIN_BOTTOM, zsd_pkg::RST_MIN_CHANGES, zsd_pkg::RST_MIN_ROWS};
		prev_black  = 1'b0;
		row_changes = '0;
		row_blacks  = '0;
		change_sum  = 0;
		striped_cnt = '0;
		black_cnt   = '0;
		used_cnt    = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part on the reset settings
		for (int i = 0; i < DIR_N; i++)
			send_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].want);
		drain();

		// settings per random phase: defaults, both extremes, wide open,
		// inverted window, a loose set, and two random sets
		open_cfg = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd1};
		phase_cfg[0] = '{8'd1, 8'd158, 8'd40, 8'd96, 8'd4, 8'd3};
		phase_cfg[1] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
		phase_cfg[2] = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
		phase_cfg[3] = open_cfg;
		phase_cfg[4] = '{8'd1, 8'd158, 8'd100, 8'd20, 8'd4, 8'd3};
		phase_cfg[5] = '{8'd3, 8'd150, 8'd0, 8'd127, 8'd2, 8'd2};
		for (int k = 6; k < N_PHASES; k++) begin
			raw = {$urandom, $urandom};
			phase_cfg[k] = raw[47:0];
		end

		for (int k = 0; k < N_PHASES; k++) begin
			apply_cfg(phase_cfg[k]);
			goal = pixels_sent + RANDOM_ITEMS / N_PHASES;
			while (pixels_sent < goal) begin
				if ($urandom_range(0, 7) == 0) begin
					// stray pixel with random fields and flags
					raw = {$urandom, $urandom};
					p = raw[$bits(zsd_pkg::pix_t)-1:0];
					send_pixel(p);
				end else begin
					gen_frame();
				end
			end
			drain();
		end

		// saturation: more used, striped and black rows than the 7-bit tallies hold
		apply_cfg(open_cfg);
		burst = 1'b0;
		for (int r = 0; r < 130; r++) begin
			for (int i = 0; i < 4; i++) begin
				p.pixel_black   = (i != 1);
				p.pixel_col     = 8'(30 + i);
				p.pixel_row     = 7'd50;
				p.left_edge     = 8'd20;
				p.right_edge    = 8'd100 - 8'd48;
				p.last_in_row   = (i == 3);
				p.last_in_frame = (i == 3) && (r == 129);
				send_pixel(p);
			end
		end

		// one all-black row past 255, then one row with more than 255 changes
		burst = 1'b1;
		for (int r = 0; r < 2; r++) begin
			for (int i = 0; i < ((r == 0) ? 270 : 257); i++) begin
				p.pixel_black   = (r == 0) ? 1'b1 : i[0];
				p.pixel_col     = 8'd30;
				p.pixel_row     = 7'd60;
				p.left_edge     = 8'd20;
				p.right_edge    = 8'd100;
				p.last_in_row   = (i == ((r == 0) ? 269 : 256));
				p.last_in_frame = p.last_in_row && (r == 1);
				send_pixel(p);
			end
		end
		burst = 1'b0;
		drain();

		if (!failed && verdict_q.size() == 0) begin
			$display("zebra_stripe_detector: match");
		end else begin
			$display("zebra_stripe_detector: mismatch");
		end
		$finish;
	end

endmodule
